### rtl/core/blu25_pkg.sv
`default_nettype none

package blu25_pkg;

    localparam int CFG_W  = 9;
    localparam int COORD_W = 10;
    localparam int PIX_W  = 8;
    localparam int IDX_W  = 9;
    localparam int WT_W   = 3;
    localparam int ODIM_W = 11;
    localparam int ACC_W  = 13;

    // register indexes on the configuration port
    localparam logic REG_IMG_WIDTH  = 1'b0;
    localparam logic REG_IMG_HEIGHT = 1'b1;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // o/5 as (o*205)>>10, then one correction step
    localparam logic [7:0]  RECIP5    = 8'd205;
    localparam int          RECIP5_SH = 10;
    // num/25 as (num*5243)>>17, exact for num below 25*256
    localparam logic [12:0] RECIP25    = 13'd5243;
    localparam int          RECIP25_SH = 17;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef struct packed {
        logic [1:0][IDX_W-1:0] idx;
        logic [1:0][WT_W-1:0]  wt;
    } axis_t;

    typedef struct packed {
        logic              is_read;
        logic              oor;
        logic [IDX_W-1:0]  wr_row;
        logic [IDX_W-1:0]  wr_col;
        logic [PIX_W-1:0]  pixel;
        axis_t             rax;
        axis_t             cax;
    } cmd_t;

    function automatic axis_t axis_taps(input logic [COORD_W-1:0] o,
                                        input logic [IDX_W-1:0] n);
        logic [17:0]        prod;
        logic [7:0]         g;
        logic [COORD_W-1:0] p;
        logic [COORD_W-1:0] g2;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        logic [COORD_W-1:0] nm1;
        axis_t              r;
        prod = 18'(o) * 18'(RECIP5);
        g    = prod[RECIP5_SH +: 8];
        p    = o - COORD_W'(g) * COORD_W'(5);
        if (p >= COORD_W'(5))
        begin
            g = g + 8'd1;
            p = p - COORD_W'(5);
        end
        g2  = {1'b0, g, 1'b0};
        nm1 = COORD_W'(n) - COORD_W'(1);
        a   = g2;
        b   = g2;
        r.wt = '0;
        case (p[2:0])
            3'd0:
            begin
                r.wt[0] = 3'd5;
                r.wt[1] = 3'd0;
            end
            3'd1:
            begin
                b = g2 + COORD_W'(1);
                r.wt[0] = 3'd3;
                r.wt[1] = 3'd2;
            end
            3'd2:
            begin
                b = g2 + COORD_W'(1);
                r.wt[0] = 3'd1;
                r.wt[1] = 3'd4;
            end
            3'd3:
            begin
                a = g2 + COORD_W'(1);
                b = g2 + COORD_W'(2);
                r.wt[0] = 3'd4;
                r.wt[1] = 3'd1;
            end
            default:
            begin
                a = g2 + COORD_W'(1);
                b = g2 + COORD_W'(2);
                r.wt[0] = 3'd2;
                r.wt[1] = 3'd3;
            end
        endcase
        // edge replication past the last pixel
        if (a > nm1)
            a = nm1;
        if (b > nm1)
            b = nm1;
        r.idx[0] = a[IDX_W-1:0];
        r.idx[1] = b[IDX_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/blu25_front.sv
`default_nettype none

module blu25_front
    import blu25_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               req_type,
    input  wire logic [COORD_W-1:0] row,
    input  wire logic [COORD_W-1:0] col,
    input  wire logic [PIX_W-1:0]   pixel,
    input  wire logic               q_full,
    output logic                    q_push,
    output cmd_t                    q_cmd
);

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [IDX_W-1:0]  w_eff;
    logic [IDX_W-1:0]  h_eff;
    logic [ODIM_W-1:0] out_w;
    logic [ODIM_W-1:0] out_h;
    logic [11:0]       w5;
    logic [11:0]       h5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(256);
            height_reg <= CFG_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMG_WIDTH:  width_reg  <= cfg_data;
                REG_IMG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, anything past the frame store acts as its size
    always_comb
    begin
        w_eff = width_reg;
        if (width_reg == '0)
            w_eff = IDX_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = IDX_W'(MAX_WIDTH);
        h_eff = height_reg;
        if (height_reg == '0)
            h_eff = IDX_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = IDX_W'(MAX_HEIGHT);
    end

    // ceil(2.5*n) = (5n+1)/2
    assign w5    = 12'(w_eff) * 12'd5 + 12'd1;
    assign h5    = 12'(h_eff) * 12'd5 + 12'd1;
    assign out_w = w5[ODIM_W:1];
    assign out_h = h5[ODIM_W:1];

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_cmd         = '0;
        q_cmd.is_read = (req_type == REQ_READ);
        q_cmd.wr_row  = row[IDX_W-1:0];
        q_cmd.wr_col  = col[IDX_W-1:0];
        q_cmd.pixel   = pixel;
        q_cmd.rax     = axis_taps(row, h_eff);
        q_cmd.cax     = axis_taps(col, w_eff);
        if (req_type == REQ_READ)
            q_cmd.oor = (ODIM_W'(row) >= out_h) || (ODIM_W'(col) >= out_w);
        else
            q_cmd.oor = (row >= COORD_W'(h_eff)) || (col >= COORD_W'(w_eff));
    end

endmodule

`default_nettype wire

### rtl/core/blu25_fifo.sv
`default_nettype none

module blu25_fifo
    import blu25_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t cmd_in,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      cmd_out
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign cmd_out   = entry_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + QPTR_W'(1);
            if (pop)
                rptr_reg <= rptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= cmd_in;
    end

endmodule

`default_nettype wire

### rtl/core/blu25_back.sv
`default_nettype none

module blu25_back
    import blu25_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire cmd_t             q_cmd,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [PIX_W-1:0]      value,
    output logic                  out_of_range
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [PIX_W-1:0]  mem [DEPTH];

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    cmd_t              cmd_reg;
    logic [1:0]        cnt_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [PIX_W-1:0]  rd_data_reg;
    logic [4:0]        rd_wt_reg;
    logic              rd_pend_reg;
    logic [PIX_W-1:0]  res_value_reg;
    logic              res_oor_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  value_reg;
    logic              oor_reg;

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [4:0]        tap_wt;
    logic [25:0]       quot_prod;
    logic [8:0]        quot;
    logic              load_out;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign mem_we = q_pop && !q_cmd.is_read && !q_cmd.oor;
    assign mem_re = (state_reg == S_RD);

    always_comb
    begin
        if (state_reg == S_RD)
            mem_addr = ADDR_W'(cmd_reg.rax.idx[cnt_reg[1]]) * ADDR_W'(MAX_WIDTH)
                     + ADDR_W'(cmd_reg.cax.idx[cnt_reg[0]]);
        else
            mem_addr = ADDR_W'(q_cmd.wr_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(q_cmd.wr_col);
    end

    // weight of the current tap in 25ths
    assign tap_wt = 5'(cmd_reg.rax.wt[cnt_reg[1]]) * 5'(cmd_reg.cax.wt[cnt_reg[0]]);

    assign quot_prod = 26'(acc_reg) * 26'(RECIP25);
    assign quot      = quot_prod[RECIP25_SH +: 9];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= q_cmd.pixel;
        else if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.is_read && !q_cmd.oor)
                        state_next = S_RD;
                    else
                        state_next = S_DONE;
                end
            end
            S_RD:
            begin
                if (cnt_reg == 2'd3)
                    state_next = S_ACC;
            end
            S_ACC:
                state_next = S_DIV;
            S_DIV:
                state_next = S_DONE;
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= mem_re;
            if (state_reg == S_RD)
                cnt_reg <= cnt_reg + 2'd1;
            else
                cnt_reg <= '0;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg       <= q_cmd;
            res_value_reg <= '0;
            res_oor_reg   <= q_cmd.oor;
        end
        rd_wt_reg <= tap_wt;
        // read data is registered and lands in the cycle after its address
        if (q_pop)
            acc_reg <= '0;
        else if (rd_pend_reg)
            acc_reg <= acc_reg + 13'(rd_wt_reg) * 13'(rd_data_reg);
        if (state_reg == S_DIV)
            res_value_reg <= (quot > 9'd255) ? 8'd255 : quot[PIX_W-1:0];
        if (load_out)
        begin
            value_reg <= res_value_reg;
            oor_reg   <= res_oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

### rtl/core/bilinear_upscale_2p5.sv
`default_nettype none

// channel   direction  handshake             payload
// cfg       in         cfg_we                cfg_index, cfg_data
// request   in         in_valid / in_stall   req_type, row, col, pixel
// result    out        out_valid / out_stall value, out_of_range
//
// a read inside the output frame has these steps in the back end: four frame store
// reads through its single port, one accumulate, one divide by 25, one handoff.
// writes and out-of-range requests skip to the handoff; a two-entry queue lets
// requests enter while the back end works. the frame store is not cleared at
// reset and the size registers come up at 256. a stalled result holds the back end.

module bilinear_upscale_2p5
    import blu25_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               req_type,
    input  wire logic [COORD_W-1:0] row,
    input  wire logic [COORD_W-1:0] col,
    input  wire logic [PIX_W-1:0]   pixel,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [PIX_W-1:0]        value,
    output logic                    out_of_range
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    blu25_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .row       (row),
        .col       (col),
        .pixel     (pixel),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    blu25_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .cmd_in    (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .cmd_out   (head_cmd)
    );

    blu25_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .out_of_range (out_of_range)
    );

endmodule

`default_nettype wire
